/* rtl/plf_pkg.sv */
// ----------------------------------------------------------------------------
// plf_pkg
// Shared types, constants and the 2^(2^-i) table builder for the power-law
// spectral filter.
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int MAX_LOG2_SIZE_DEF = 10;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 48;
  localparam int BETA_W  = 15;
  localparam int SIZE_W  = 4;
  localparam int MANT_W  = 31;   // Q1.30 mantissa
  localparam int EXP_FB  = 29;   // exponent fraction bits
  localparam int NLOG    = 16;   // log2 fraction bits, one squaring each
  localparam int E_W     = 40;   // exponent accumulator width
  localparam int J_W     = E_W - EXP_FB;
  localparam int T_W     = J_W + 1;
  localparam int Q_DEPTH = 4;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BETA = 1'b0,
    REG_SIZE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             dc;
    logic             neg;
    logic [VAL_W-1:0] mag;
  } carry_t;

  typedef logic [0:EXP_FB][31:0] rom_t;

  function automatic logic [63:0] isqrt64(logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] v;
    v = 64'd1 << 31;
    t[0] = v[31:0];
    for (int i = 1; i <= EXP_FB; i++) begin
      v = isqrt64(v << 30);
      t[i] = v[31:0];
    end
    return t;
  endfunction

endpackage

/* rtl/plf_front.sv */
// ----------------------------------------------------------------------------
// plf_front
// Accepts bins, wraps indices to signed frequencies, forms the squared
// radius and splits the bin into sign and magnitude.
// ----------------------------------------------------------------------------
module plf_front #(
  parameter int MAX_LOG2_SIZE = plf_pkg::MAX_LOG2_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [plf_pkg::SIZE_W-1:0]  l_eff,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [plf_pkg::IDX_W-1:0]   in_row_index,
  input  logic [plf_pkg::IDX_W-1:0]   in_col_index,
  input  logic signed [plf_pkg::VAL_W-1:0] in_bin_value,
  output logic                        push,
  output logic [2*MAX_LOG2_SIZE-1:0]  push_s,
  output plf_pkg::carry_t             push_carry,
  input  logic                        q_full
);

  localparam int S_W = 2 * MAX_LOG2_SIZE;
  localparam int KW  = ((MAX_LOG2_SIZE > plf_pkg::IDX_W) ? MAX_LOG2_SIZE
                        : plf_pkg::IDX_W) + 1;

  logic                 f_valid_r, f_valid_nxt;
  logic [S_W-1:0]       f_s_r, f_s_nxt;
  plf_pkg::carry_t      f_c_r, f_c_nxt;
  logic [MAX_LOG2_SIZE-1:0] kr, kc;
  logic                 accept;

  function automatic logic [MAX_LOG2_SIZE-1:0] fmag(
    logic [plf_pkg::IDX_W-1:0] idx, logic [plf_pkg::SIZE_W-1:0] l);
    logic [KW-1:0] n;
    logic [KW-1:0] ix;
    logic [KW-1:0] k;
    n  = KW'(1) << l;
    ix = KW'(idx) & (n - KW'(1));
    if (l != '0 && ix >= (n >> 1)) k = n - ix;
    else k = ix;
    return k[MAX_LOG2_SIZE-1:0];
  endfunction

  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid_r && !q_full;
  assign push_s   = f_s_r;
  assign push_carry = f_c_r;

  always_comb begin
    kr = fmag(in_row_index, l_eff);
    kc = fmag(in_col_index, l_eff);
    f_s_nxt = S_W'(kr * kr) + S_W'(kc * kc);
    f_c_nxt.dc  = (f_s_nxt == '0);
    f_c_nxt.neg = in_bin_value[plf_pkg::VAL_W-1];
    f_c_nxt.mag = in_bin_value[plf_pkg::VAL_W-1] ? (~in_bin_value + 1'b1)
                                                   : in_bin_value;
    f_valid_nxt = f_valid_r;
    if (accept) f_valid_nxt = 1'b1;
    else if (push) f_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_s_r <= f_s_nxt;
      f_c_r <= f_c_nxt;
    end
  end

endmodule

/* rtl/plf_queue.sv */
// ----------------------------------------------------------------------------
// plf_queue
// Small register FIFO between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module plf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] head
);

  localparam int D   = plf_pkg::Q_DEPTH;
  localparam int A_W = $clog2(D);

  logic [W-1:0]   mem [D];
  logic [A_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [A_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (A_W+1)'(D));
  assign valid = (cnt_r != '0);
  assign head  = mem[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (A_W+1)'(push) - (A_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_data;
  end

endmodule

/* rtl/plf_back.sv */
// ----------------------------------------------------------------------------
// plf_back
// Arithmetic pipeline: log2 of the squared radius by repeated squaring,
// exponent, 2^-e by table products, bin scaling, rounding and saturation.
// ----------------------------------------------------------------------------
module plf_back #(
  parameter int MAX_LOG2_SIZE = plf_pkg::MAX_LOG2_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [plf_pkg::BETA_W-1:0] beta,
  input  logic [plf_pkg::SIZE_W-1:0]        l_eff,
  input  logic                              q_valid,
  input  logic [2*MAX_LOG2_SIZE-1:0]        q_s,
  input  plf_pkg::carry_t                   q_carry,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [plf_pkg::VAL_W-1:0]  out_scaled_value,
  output logic                              out_saturated
);

  localparam int S_W   = 2 * MAX_LOG2_SIZE;
  localparam int P_W   = (S_W > 2) ? $clog2(S_W) : 1;
  localparam int LG_W  = P_W + plf_pkg::NLOG;
  localparam int PB_W  = plf_pkg::BETA_W + LG_W + 1;
  localparam int TL_W  = 21;
  localparam int MW    = plf_pkg::MANT_W;
  localparam int NEXP  = plf_pkg::EXP_FB;
  localparam int E_W   = plf_pkg::E_W;
  localparam int J_W   = plf_pkg::J_W;
  localparam int T_W   = plf_pkg::T_W;
  localparam int VW    = plf_pkg::VAL_W;
  localparam int PR_W  = VW + MW;          // 79-bit product
  localparam int SM_W  = PR_W + 1;
  localparam plf_pkg::rom_t POW_ROM = plf_pkg::build_rom();

  logic en;

  // normalize stage
  logic                 b0_v_r;
  plf_pkg::carry_t      b0_c_r;
  logic [MW-1:0]        b0_m_r, b0_m_nxt;
  logic [P_W-1:0]       b0_p_r, b0_p_nxt;

  // log2 squaring stages
  logic                 lg_v_r [plf_pkg::NLOG];
  plf_pkg::carry_t      lg_c_r [plf_pkg::NLOG];
  logic [MW-1:0]        lg_m_r [plf_pkg::NLOG];
  logic [P_W-1:0]       lg_p_r [plf_pkg::NLOG];
  logic [plf_pkg::NLOG-1:0] lg_f_r [plf_pkg::NLOG];

  // exponent stages
  logic                 e1_v_r;
  plf_pkg::carry_t      e1_c_r;
  logic signed [PB_W-1:0] e1_pb_r;
  logic signed [TL_W-1:0] e1_tl_r;
  logic                 e2_v_r;
  plf_pkg::carry_t      e2_c_r;
  logic signed [J_W-1:0] e2_j_r;
  logic [NEXP-1:0]      e2_h_r;
  logic signed [E_W-1:0] e_sum, e_neg;

  // 2^h product stages
  logic                 x_v_r [NEXP];
  plf_pkg::carry_t      x_c_r [NEXP];
  logic signed [J_W-1:0] x_j_r [NEXP];
  logic [NEXP-1:0]      x_h_r [NEXP];
  logic [MW-1:0]        x_g_r [NEXP];

  // scaling and rounding
  logic                 m1_v_r;
  plf_pkg::carry_t      m1_c_r;
  logic [55:0]          m1_a_r;
  logic [MW-1:0]        m1_g_r;
  logic signed [T_W-1:0] m1_t_r;
  logic                 m2_v_r, m2_dc_r, m2_neg_r;
  logic [PR_W-1:0]      m2_p_r;
  logic signed [T_W-1:0] m2_t_r;
  logic                 r1_v_r, r1_dc_r, r1_neg_r;
  logic [SM_W-1:0]      r1_sum_r, r1_sum_nxt;
  logic signed [T_W-1:0] r1_t_r;
  logic                 r2_v_r, r2_dc_r, r2_neg_r, r2_over_r, r2_over_nxt;
  logic [VW-1:0]        r2_val_r, r2_val_nxt;
  logic                 o_v_r, o_sat_r, o_sat_nxt;
  logic [VW-1:0]        o_val_r, o_val_nxt;

  assign en        = !(o_v_r && out_stall);
  assign q_pop     = en && q_valid;
  assign out_valid = o_v_r;
  assign out_scaled_value = o_val_r;
  assign out_saturated    = o_sat_r;

  // leading one of the squared radius, mantissa to Q1.30
  always_comb begin
    b0_p_nxt = '0;
    for (int k = 1; k < S_W; k++) begin
      if (q_s[k]) b0_p_nxt = P_W'(k);
    end
    b0_m_nxt = MW'(q_s) << (MW - 1 - int'(b0_p_nxt));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_c_r <= q_carry;
      b0_m_r <= b0_m_nxt;
      b0_p_r <= b0_p_nxt;
    end
  end

  for (genvar k = 0; k < plf_pkg::NLOG; k++) begin : g_log
    logic [2*MW-1:0]      sq;
    logic [MW-1:0]        m_in;
    logic [plf_pkg::NLOG-1:0] f_in;
    logic [P_W-1:0]       p_in;
    plf_pkg::carry_t      c_in;
    if (k == 0) begin : g_first
      assign m_in = b0_m_r;
      assign f_in = '0;
      assign p_in = b0_p_r;
      assign c_in = b0_c_r;
    end else begin : g_rest
      assign m_in = lg_m_r[k-1];
      assign f_in = lg_f_r[k-1];
      assign p_in = lg_p_r[k-1];
      assign c_in = lg_c_r[k-1];
    end
    assign sq = m_in * m_in;
    always_ff @(posedge clk) begin
      if (en) begin
        lg_c_r[k] <= c_in;
        lg_p_r[k] <= p_in;
        // square at or above 2.0: emit a one and halve
        lg_m_r[k] <= sq[2*MW-1] ? sq[2*MW-1:MW] : sq[2*MW-2:MW-1];
        lg_f_r[k] <= {f_in[plf_pkg::NLOG-2:0], sq[2*MW-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_c_r  <= lg_c_r[plf_pkg::NLOG-1];
      e1_pb_r <= beta * $signed({1'b0, lg_p_r[plf_pkg::NLOG-1],
                                 lg_f_r[plf_pkg::NLOG-1]});
      e1_tl_r <= TL_W'($signed({1'b0, l_eff}) *
                       (16'sd4096 - 16'(beta)));
    end
  end

  always_comb begin
    e_sum = (E_W'(e1_tl_r) <<< 17) + E_W'(e1_pb_r);
    e_neg = -e_sum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_c_r <= e1_c_r;
      e2_j_r <= e_neg[E_W-1:NEXP];
      e2_h_r <= e_neg[NEXP-1:0];
    end
  end

  for (genvar i = 0; i < NEXP; i++) begin : g_exp
    logic [2*MW-1:0]       pr;
    logic [MW-1:0]         g_in;
    logic [NEXP-1:0]       h_in;
    logic signed [J_W-1:0] j_in;
    plf_pkg::carry_t       c_in;
    if (i == 0) begin : g_first
      assign g_in = MW'(1) << (MW - 1);
      assign h_in = e2_h_r;
      assign j_in = e2_j_r;
      assign c_in = e2_c_r;
    end else begin : g_rest
      assign g_in = x_g_r[i-1];
      assign h_in = x_h_r[i-1];
      assign j_in = x_j_r[i-1];
      assign c_in = x_c_r[i-1];
    end
    assign pr = g_in * POW_ROM[i+1][MW-1:0];
    always_ff @(posedge clk) begin
      if (en) begin
        x_c_r[i] <= c_in;
        x_h_r[i] <= h_in;
        x_j_r[i] <= j_in;
        x_g_r[i] <= h_in[NEXP-1-i] ? pr[2*MW-2:MW-1] : g_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_c_r <= x_c_r[NEXP-1];
      m1_g_r <= x_g_r[NEXP-1];
      m1_a_r <= x_c_r[NEXP-1].mag[VW-1:24] * 32'(x_g_r[NEXP-1]);
      m1_t_r <= T_W'(30) - T_W'(x_j_r[NEXP-1]);
      m2_dc_r  <= m1_c_r.dc;
      m2_neg_r <= m1_c_r.neg;
      m2_t_r   <= m1_t_r;
      m2_p_r   <= PR_W'({m1_a_r, 24'd0}) + PR_W'(m1_c_r.mag[23:0] * m1_g_r);
    end
  end

  // add the rounding half for a right shift
  always_comb begin
    r1_sum_nxt = SM_W'(m2_p_r);
    if (m2_t_r >= T_W'(1) && m2_t_r <= T_W'(80))
      r1_sum_nxt = SM_W'(m2_p_r) + (SM_W'(1) << 7'(m2_t_r - T_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_dc_r  <= m2_dc_r;
      r1_neg_r <= m2_neg_r;
      r1_t_r   <= m2_t_r;
      r1_sum_r <= r1_sum_nxt;
    end
  end

  always_comb begin
    logic [SM_W-1:0]       shr;
    logic [PR_W+VW-1:0]    shl;
    logic signed [T_W-1:0] ls;
    shr = r1_sum_r >> 7'(r1_t_r);
    ls  = -r1_t_r;
    shl = (PR_W+VW)'(r1_sum_r[PR_W-1:0]) << 6'(ls);
    r2_val_nxt  = '0;
    r2_over_nxt = 1'b0;
    priority if (r1_t_r > T_W'(80)) begin
      r2_val_nxt  = '0;
    end else if (r1_t_r >= T_W'(1)) begin
      r2_val_nxt  = shr[VW-1:0];
      r2_over_nxt = |shr[SM_W-1:VW];
    end else if (ls >= T_W'(VW)) begin
      r2_over_nxt = (r1_sum_r[PR_W-1:0] != '0);
    end else begin
      r2_val_nxt  = shl[VW-1:0];
      r2_over_nxt = |shl[PR_W+VW-1:VW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_dc_r   <= r1_dc_r;
      r2_neg_r  <= r1_neg_r;
      r2_val_r  <= r2_val_nxt;
      r2_over_r <= r2_over_nxt;
    end
  end

  // clip to the signed range, then apply the sign
  always_comb begin
    o_sat_nxt = r2_over_r || (r2_neg_r ? (r2_val_r > (VW'(1) << (VW-1)))
                                       : (r2_val_r > ((VW'(1) << (VW-1)) - 1'b1)));
    if (r2_neg_r) o_val_nxt = o_sat_nxt ? (VW'(1) << (VW-1)) : (~r2_val_r + 1'b1);
    else o_val_nxt = o_sat_nxt ? ((VW'(1) << (VW-1)) - 1'b1) : r2_val_r;
    if (r2_dc_r) begin
      o_sat_nxt = 1'b0;
      o_val_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_val_r <= o_val_nxt;
      o_sat_r <= o_sat_nxt;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      r1_v_r <= 1'b0;
      r2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
      for (int k = 0; k < plf_pkg::NLOG; k++) lg_v_r[k] <= 1'b0;
      for (int i = 0; i < NEXP; i++) x_v_r[i] <= 1'b0;
    end else if (en) begin
      b0_v_r <= q_valid;
      lg_v_r[0] <= b0_v_r;
      for (int k = 1; k < plf_pkg::NLOG; k++) lg_v_r[k] <= lg_v_r[k-1];
      e1_v_r <= lg_v_r[plf_pkg::NLOG-1];
      e2_v_r <= e1_v_r;
      x_v_r[0] <= e2_v_r;
      for (int i = 1; i < NEXP; i++) x_v_r[i] <= x_v_r[i-1];
      m1_v_r <= x_v_r[NEXP-1];
      m2_v_r <= m1_v_r;
      r1_v_r <= m2_v_r;
      r2_v_r <= r1_v_r;
      o_v_r  <= r2_v_r;
    end
  end

endmodule

/* rtl/power_law_spectral_filter.sv */
// ----------------------------------------------------------------------------
// power_law_spectral_filter
// Divides one FFT bin by N^(1-beta) * r^beta with rounding and saturation.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while out_stall is low; every multiply
//   stage of the log2, 2^x and scaling pipeline takes a new item each cycle.
// A four-entry queue parts the front from the arithmetic back end.
// Reset: synchronous, active low; beta = 1.0, size_log2 = 8, pipeline empty.
module power_law_spectral_filter #(
  parameter int MAX_LOG2_SIZE = plf_pkg::MAX_LOG2_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [plf_pkg::IDX_W-1:0]           in_row_index,
  input  logic [plf_pkg::IDX_W-1:0]           in_col_index,
  input  logic signed [plf_pkg::VAL_W-1:0]    in_bin_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plf_pkg::VAL_W-1:0]    out_scaled_value,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [plf_pkg::BETA_W-1:0]          cfg_data
);

  localparam int S_W = 2 * MAX_LOG2_SIZE;
  localparam int QW  = S_W + $bits(plf_pkg::carry_t);

  logic signed [plf_pkg::BETA_W-1:0] beta_r, beta_nxt;
  logic [plf_pkg::SIZE_W-1:0]        size_r, size_nxt, l_eff;
  logic                              push, q_full, q_pop, q_valid;
  logic [S_W-1:0]                    push_s;
  plf_pkg::carry_t                   push_carry, q_carry;
  logic [QW-1:0]                     q_head;

  assign cfg_ready = 1'b1;
  assign l_eff = (size_r > plf_pkg::SIZE_W'(MAX_LOG2_SIZE))
                 ? plf_pkg::SIZE_W'(MAX_LOG2_SIZE) : size_r;

  always_comb begin
    beta_nxt = beta_r;
    size_nxt = size_r;
    if (cfg_valid) begin
      unique case (plf_pkg::cfg_reg_t'(cfg_index))
        plf_pkg::REG_BETA: beta_nxt = cfg_data;
        plf_pkg::REG_SIZE: size_nxt = cfg_data[plf_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= plf_pkg::BETA_W'(4096);
      size_r <= plf_pkg::SIZE_W'(8);
    end else begin
      beta_r <= beta_nxt;
      size_r <= size_nxt;
    end
  end

  plf_front #(.MAX_LOG2_SIZE(MAX_LOG2_SIZE)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .l_eff        (l_eff),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_bin_value (in_bin_value),
    .push         (push),
    .push_s       (push_s),
    .push_carry   (push_carry),
    .q_full       (q_full)
  );

  plf_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_s, push_carry}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign q_carry = q_head[$bits(plf_pkg::carry_t)-1:0];

  plf_back #(.MAX_LOG2_SIZE(MAX_LOG2_SIZE)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .beta             (beta_r),
    .l_eff            (l_eff),
    .q_valid          (q_valid),
    .q_s              (q_head[QW-1:$bits(plf_pkg::carry_t)]),
    .q_carry          (q_carry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scaled_value (out_scaled_value),
    .out_saturated    (out_saturated)
  );

endmodule
